// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the group membership table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that the consequent holds in the cycle of the antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/gmt_pkg.sv =====
// Types, constants and codes shared by the group membership table modules.
`timescale 1ns / 1ps
package gmt_pkg;

   localparam int NUM_GROUPS_DEFAULT  = 16;
   localparam int GROUP_SLOTS_DEFAULT = 128;

   localparam int OP_W        = 2;
   localparam int GID_W       = 8;
   localparam int MID_W       = 16;
   localparam int STATUS_W    = 3;
   localparam int CNT_W       = 8;
   localparam int CFG_COUNT_W = 5;
   localparam int CAP_W       = 8;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = 3;

   localparam logic [CFG_COUNT_W-1:0] GROUP_COUNT_RESET    = 5'd16;
   localparam logic [CAP_W-1:0]       GROUP_CAPACITY_RESET = 8'd100;

   // register index, taken from the word address bit
   localparam logic REG_GROUP_COUNT    = 1'b0;
   localparam logic REG_GROUP_CAPACITY = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_JOIN  = 2'd0,
      OP_LEAVE = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK            = 3'd0,
      ST_INVALID_GROUP = 3'd1,
      ST_FULL          = 3'd2,
      ST_ALREADY       = 3'd3,
      ST_NOT_FOUND     = 3'd4,
      ST_NOT_MEMBER    = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ_SIZE,
      S_CHECK,
      S_SCAN,
      S_DRAIN,
      S_UPDATE,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic capture;
      logic size_read;
      logic check;
      logic scan_step;
      logic update;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic scan_last;
      logic need_scan;
   } stat_type;

endpackage

// ===== hw/rtl/group_membership_table.sv =====
// Top level of the group membership table: register port, sequencer and datapath.
//
// Each request transfer carries an operation (join, leave or query), a group id
// and a member id; each one yields exactly one response transfer with a status,
// the group's member count afterwards and a full flag.
// The block works on one request at a time. A join or leave that has to search
// the group walks the slot store of the group one slot per cycle through its
// single read port before it shows its response. Rejected joins, leaves of an
// empty or invalid group and queries skip the search.
// A new request is taken once the previous result is loaded into the response
// register, even while that response still waits under rsp_stall; a finished
// result waits in its own state until the response register frees up.
// After reset the slot store is swept clear, one entry per cycle, over all
// NUM_GROUPS * GROUP_SLOTS entries (2048 at the default size); req_stall stays
// high during that sweep, while register writes are taken as usual.
// Registers: group_count at byte address 0, group_capacity at byte address 4.
// Write them only while no request is in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module group_membership_table #(
   parameter int NUM_GROUPS  = gmt_pkg::NUM_GROUPS_DEFAULT,
   parameter int GROUP_SLOTS = gmt_pkg::GROUP_SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [gmt_pkg::OP_W-1:0]      req_operation,
   input  logic [gmt_pkg::GID_W-1:0]     req_group_id,
   input  logic [gmt_pkg::MID_W-1:0]     req_member_id,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gmt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [gmt_pkg::CNT_W-1:0]     rsp_member_count,
   output logic                          rsp_group_full,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [gmt_pkg::ADDR_W-1:0]    paddr,
   input  logic [gmt_pkg::DATA_W-1:0]    pwdata,
   output logic [gmt_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);
   import gmt_pkg::*;

   logic [CFG_COUNT_W-1:0] count_ff, count_in;
   logic [CAP_W-1:0]       capacity_ff, capacity_in;
   logic                   reg_write;
   logic                   reg_sel;

   cmd_type  cmd;
   stat_type stat;

   // transfer classes named for the checks at the end
   logic req_xfer, inv_rsp, zero_rsp, full_rsp;

   // Register port: zero wait states, the word address bit picks the register.
   assign pready    = 1'b1;
   assign reg_sel   = paddr[2];
   assign reg_write = psel && penable && pwrite && pready;

   always_comb begin
      count_in    = count_ff;
      capacity_in = capacity_ff;
      if (reg_write) begin
         case (reg_sel)
            REG_GROUP_COUNT:    count_in    = pwdata[CFG_COUNT_W-1:0];
            REG_GROUP_CAPACITY: capacity_in = pwdata[CAP_W-1:0];
            default:            count_in    = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= GROUP_COUNT_RESET;
         capacity_ff <= GROUP_CAPACITY_RESET;
      end else begin
         count_ff    <= count_in;
         capacity_ff <= capacity_in;
      end
   end

   // Read back the addressed register.
   always_comb begin
      case (reg_sel)
         REG_GROUP_COUNT:    prdata = {{(DATA_W - CFG_COUNT_W){1'b0}}, count_ff};
         REG_GROUP_CAPACITY: prdata = {{(DATA_W - CAP_W){1'b0}}, capacity_ff};
         default:            prdata = '0;
      endcase
   end

   // Sequencer: owns both handshakes and steps the datapath.
   gmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: slot and size stores, the slot search and the response register.
   gmt_dp #(
      .NUM_GROUPS  (NUM_GROUPS),
      .GROUP_SLOTS (GROUP_SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_operation),
      .req_group_id     (req_group_id),
      .req_member_id    (req_member_id),
      .cfg_count        (count_ff),
      .cfg_capacity     (capacity_ff),
      .rsp_status       (rsp_status),
      .rsp_member_count (rsp_member_count),
      .rsp_group_full   (rsp_group_full)
   );

   assign req_xfer = req_valid && !req_stall;
   assign inv_rsp  = rsp_valid && (rsp_status == ST_INVALID_GROUP);
   assign zero_rsp = (rsp_member_count == '0) && !rsp_group_full;
   assign full_rsp = rsp_valid && (rsp_status == ST_FULL);

   // No request may be taken while the clearing sweep runs.
   `ASSERT_IMPL(a_no_accept_in_clear, clock, reset, cmd.clear_step, req_stall, "taken in sweep")
   // One request at a time: the cycle after a transfer the channel is stalled.
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_xfer, req_stall, "second request in flight")
   // An invalid group reports no members and not full.
   `ASSERT_IMPL(a_invalid_zero, clock, reset, inv_rsp, zero_rsp, "invalid group result nonzero")
   // A full rejection always carries the full flag.
   `ASSERT_IMPL(a_full_flag, clock, reset, full_rsp, rsp_group_full, "full status, flag low")

endmodule

// ===== hw/rtl/gmt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module gmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/gmt_ctrl.sv =====
// Sequencer of the group membership table: clearing pass, lookup, scan and result.
`timescale 1ns / 1ps
module gmt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  gmt_pkg::stat_type stat,
   output gmt_pkg::cmd_type  cmd
);
   import gmt_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_READ_SIZE;
            end
         end
         S_READ_SIZE: begin
            cmd.size_read = 1'b1;
            state_in      = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.need_scan ? S_SCAN : S_RESULT;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_RESULT;
         end
         S_RESULT: begin
            // wait until the output register is free or being emptied
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

endmodule

// ===== hw/rtl/gmt_dp.sv =====
// Datapath of the group membership table: slot and size stores, scan and result registers.
`timescale 1ns / 1ps
module gmt_dp #(
   parameter int NUM_GROUPS  = gmt_pkg::NUM_GROUPS_DEFAULT,
   parameter int GROUP_SLOTS = gmt_pkg::GROUP_SLOTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  gmt_pkg::cmd_type                 cmd,
   output gmt_pkg::stat_type                stat,
   input  logic [gmt_pkg::OP_W-1:0]         req_operation,
   input  logic [gmt_pkg::GID_W-1:0]        req_group_id,
   input  logic [gmt_pkg::MID_W-1:0]        req_member_id,
   input  logic [gmt_pkg::CFG_COUNT_W-1:0]  cfg_count,
   input  logic [gmt_pkg::CAP_W-1:0]        cfg_capacity,
   output logic [gmt_pkg::STATUS_W-1:0]     rsp_status,
   output logic [gmt_pkg::CNT_W-1:0]        rsp_member_count,
   output logic                             rsp_group_full
);
   import gmt_pkg::*;

   localparam int TOTAL  = NUM_GROUPS * GROUP_SLOTS;
   localparam int AW     = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int GW     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int SLW    = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
   localparam int SLOT_W = MID_W + 1;

   localparam logic [AW-1:0]  TOTAL_LAST = AW'(TOTAL - 1);
   localparam logic [SLW-1:0] SLOT_LAST  = SLW'(GROUP_SLOTS - 1);
   localparam logic [AW:0]    NG_CLR     = (AW + 1)'(NUM_GROUPS);
   localparam logic [8:0]     NG_ID      = 9'(NUM_GROUPS);
   localparam logic [10:0]    SLOTS_CAP  = 11'(GROUP_SLOTS);
   localparam logic [AW-1:0]  SLOTS_A    = AW'(GROUP_SLOTS);

   // captured item
   logic [OP_W-1:0]  op_ff;
   logic [GID_W-1:0] gid_ff;
   logic [MID_W-1:0] mid_ff;
   logic [AW-1:0]    base_ff;
   logic [CNT_W-1:0] size_ff;

   // scan state
   logic [AW-1:0]    clr_ff;
   logic [SLW-1:0]   scan_ff;
   logic             pend_ff;
   logic [SLW-1:0]   pidx_ff;
   logic             hit_ff;
   logic [SLW-1:0]   hit_idx_ff;
   logic             free_ff;
   logic [SLW-1:0]   free_idx_ff;

   // result and output registers
   status_type       res_status_ff;
   logic [CNT_W-1:0] res_count_ff;
   logic             res_full_ff;
   status_type       out_status_ff;
   logic [CNT_W-1:0] out_count_ff;
   logic             out_full_ff;

   logic [SLOT_W-1:0] slot_rd;
   logic [CNT_W-1:0]  size_rd;
   logic              slot_we, size_we;
   logic [AW-1:0]     slot_wa;
   logic [SLOT_W-1:0] slot_wd;
   logic [GW-1:0]     size_wa;
   logic [CNT_W-1:0]  size_wd;

   logic [8:0]       gid_m1;
   logic [GW-1:0]    grp;
   logic             stored, join_ok, is_join, is_leave;
   logic [CAP_W-1:0] cap_eff;
   logic             size_full;

   status_type       chk_status;
   logic [CNT_W-1:0] chk_count;
   logic             chk_full;
   logic             need_scan;

   logic             chg, do_write;
   logic [CNT_W-1:0] size_new, upd_count;
   status_type       upd_status;
   logic [SLW-1:0]   upd_idx;
   logic             clr_grp;

   assign gid_m1   = {1'b0, gid_ff} - 9'd1;
   assign grp      = gid_m1[GW-1:0];
   assign stored   = (gid_ff != '0) && ({1'b0, gid_ff} <= NG_ID);
   assign join_ok  = stored && (gid_ff <= {3'b000, cfg_count});
   assign is_join  = (op_ff == OP_JOIN);
   assign is_leave = (op_ff == OP_LEAVE);
   assign cap_eff  = ({3'b000, cfg_capacity} > SLOTS_CAP) ? SLOTS_CAP[CAP_W-1:0] : cfg_capacity;
   assign size_full = (size_rd >= cap_eff);

   // decision on the group size alone
   always_comb begin
      chk_status = ST_OK;
      chk_count  = size_rd;
      chk_full   = size_full;
      need_scan  = 1'b0;
      case (op_ff)
         OP_JOIN: begin
            if (!join_ok) begin
               chk_status = ST_INVALID_GROUP;
               chk_count  = '0;
               chk_full   = 1'b0;
            end else if (size_full) begin
               chk_status = ST_FULL;
               chk_full   = 1'b1;
            end else begin
               need_scan = 1'b1;
            end
         end
         OP_LEAVE: begin
            if (!stored || (size_rd == '0)) begin
               chk_status = ST_NOT_FOUND;
               chk_count  = '0;
               chk_full   = stored && (cap_eff == '0);
            end else begin
               need_scan = 1'b1;
            end
         end
         default: begin
            if (!stored) begin
               chk_count = '0;
               chk_full  = 1'b0;
            end
         end
      endcase
   end

   // decision after the scan
   always_comb begin
      chg        = is_join ? !hit_ff : hit_ff;
      size_new   = is_join ? size_ff + CNT_W'(1) : size_ff - CNT_W'(1);
      upd_count  = chg ? size_new : size_ff;
      upd_idx    = is_join ? free_idx_ff : hit_idx_ff;
      do_write   = cmd.update && chg && (is_join || is_leave);
      if (is_join) begin
         upd_status = hit_ff ? ST_ALREADY : ST_OK;
      end else begin
         upd_status = hit_ff ? ST_OK : ST_NOT_MEMBER;
      end
   end

   assign clr_grp = ({1'b0, clr_ff} < NG_CLR);

   always_comb begin
      if (cmd.clear_step) begin
         slot_we = 1'b1;
         slot_wa = clr_ff;
         slot_wd = '0;
         size_we = clr_grp;
         size_wa = clr_ff[GW-1:0];
         size_wd = '0;
      end else begin
         slot_we = do_write;
         slot_wa = base_ff + AW'(upd_idx);
         slot_wd = {is_join, mid_ff};
         size_we = do_write;
         size_wa = grp;
         size_wd = size_new;
      end
   end

   gmt_ram #(.WIDTH(SLOT_W), .DEPTH(TOTAL)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_wa),
      .wr_data (slot_wd),
      .rd_en   (cmd.scan_step),
      .rd_addr (base_ff + AW'(scan_ff)),
      .rd_data (slot_rd)
   );

   gmt_ram #(.WIDTH(CNT_W), .DEPTH(NUM_GROUPS)) u_size_ram (
      .clock   (clock),
      .wr_en   (size_we),
      .wr_addr (size_wa),
      .wr_data (size_wd),
      .rd_en   (cmd.size_read),
      .rd_addr (grp),
      .rd_data (size_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + AW'(1);
         end
         pend_ff <= cmd.scan_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_operation;
         gid_ff <= req_group_id;
         mid_ff <= req_member_id;
      end
      if (cmd.size_read) begin
         base_ff <= AW'(grp) * SLOTS_A;
      end
      if (cmd.check) begin
         size_ff       <= size_rd;
         res_status_ff <= chk_status;
         res_count_ff  <= chk_count;
         res_full_ff   <= chk_full;
         scan_ff       <= '0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
      end
      if (cmd.scan_step) begin
         scan_ff <= scan_ff + SLW'(1);
         pidx_ff <= scan_ff;
      end
      // evaluate the slot read in the previous cycle; keep the first match and first hole
      if (pend_ff) begin
         if (slot_rd[MID_W] && (slot_rd[MID_W-1:0] == mid_ff) && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= pidx_ff;
         end
         if (!slot_rd[MID_W] && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= pidx_ff;
         end
      end
      if (cmd.update) begin
         res_status_ff <= upd_status;
         res_count_ff  <= upd_count;
         res_full_ff   <= (upd_count >= cap_eff);
      end
      if (cmd.emit) begin
         out_status_ff <= res_status_ff;
         out_count_ff  <= res_count_ff;
         out_full_ff   <= res_full_ff;
      end
   end

   assign stat.clear_last = (clr_ff == TOTAL_LAST);
   assign stat.scan_last  = (scan_ff == SLOT_LAST);
   assign stat.need_scan  = need_scan;

   assign rsp_status       = out_status_ff;
   assign rsp_member_count = out_count_ff;
   assign rsp_group_full   = out_full_ff;

endmodule
